@@ design/lsfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame shifter package
// Shared sizes, command codes, controller states and the control bundle.
// ----------------------------------------------------------------------------
package lsfs_pkg;

  localparam int MAX_LEDS = 32;
  localparam int ADDR_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int LED_W    = $clog2(MAX_LEDS + 1);
  localparam int CH_W     = 7;
  localparam int PIX_W    = 3 * CH_W;
  localparam int IDX_W    = 10;
  localparam int ACT_W    = 6;
  localparam int COLOR_W  = 23;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 6'd32;

  localparam logic [2:0] CMD_WRITE_CH  = 3'd0;
  localparam logic [2:0] CMD_WRITE_PKD = 3'd1;
  localparam logic [2:0] CMD_READ      = 3'd2;
  localparam logic [2:0] CMD_START     = 3'd3;
  localparam logic [2:0] CMD_TICK      = 3'd4;
  localparam logic [2:0] CMD_PRIME     = 3'd5;

  localparam logic [1:0] CH_GREEN = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_t;

endpackage

@@ design/lsfs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lsfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/lsfs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame shifter controller
// Two-state sequencer: capture a request, then execute it in the datapath.
// ----------------------------------------------------------------------------
module lsfs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output lsfs_pkg::ctrl_t ctrl
);

  lsfs_pkg::state_t state_r;
  lsfs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsfs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsfs_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = lsfs_pkg::ST_EXEC;
        end
      end
      lsfs_pkg::ST_EXEC: begin
        state_nxt = lsfs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lsfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy         = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.execute = 1'b0;
    unique case (state_r)
      lsfs_pkg::ST_IDLE: begin
        ctrl.capture = start;
      end
      lsfs_pkg::ST_EXEC: begin
        busy         = 1'b1;
        ctrl.execute = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ design/lsfs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame shifter datapath
// Pixel store, frame position counters, shift register and result registers.
// ----------------------------------------------------------------------------
module lsfs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsfs_pkg::ctrl_t               ctrl,
  input  logic                          cfg_we,
  input  logic [lsfs_pkg::ACT_W-1:0]    cfg_wdata,
  input  logic [2:0]                    in_cmd,
  input  logic [lsfs_pkg::IDX_W-1:0]    in_pixel_index,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  input  logic [23:0]                   in_packed_color,
  output logic                          out_valid,
  output logic [lsfs_pkg::COLOR_W-1:0]  out_read_color,
  output logic                          out_data_bit,
  output logic                          out_clock_pulse,
  output logic                          out_busy_res,
  output logic                          out_sequence_done
);

  localparam logic [lsfs_pkg::LED_W-1:0] LAST_LED = lsfs_pkg::LED_W'(lsfs_pkg::MAX_LEDS);

  // Captured request.
  logic [2:0]                 cmd_r;
  logic [lsfs_pkg::IDX_W-1:0] idx_r;
  logic [7:0]                 red_r;
  logic [7:0]                 green_r;
  logic [7:0]                 blue_r;
  logic [23:0]                packed_r;

  logic [lsfs_pkg::ACT_W-1:0] active_r;

  // Frame state.
  logic                       sending_r, sending_nxt;
  logic                       priming_r, priming_nxt;
  logic [lsfs_pkg::LED_W-1:0] led_r, led_nxt;
  logic [1:0]                 chan_r, chan_nxt;
  logic [2:0]                 bit_r, bit_nxt;
  logic [7:0]                 shift_r, shift_nxt;

  // Pixel store and its written flags.
  logic [lsfs_pkg::MAX_LEDS-1:0] pix_valid_r;
  logic                          rd_valid_r;
  logic                          ram_we;
  logic [lsfs_pkg::PIX_W-1:0]    ram_wdata;
  logic [lsfs_pkg::ADDR_W-1:0]   ram_raddr;
  logic [lsfs_pkg::PIX_W-1:0]    ram_rdata;

  // Position of the byte that follows the current one.
  logic [lsfs_pkg::LED_W-1:0] step_led;
  logic [1:0]                 step_chan;
  logic                       index_ok;
  logic [lsfs_pkg::CH_W-1:0]  step_ch;
  logic [7:0]                 step_byte;
  logic [7:0]                 first_byte;

  // Result registers.
  logic                         out_valid_r;
  logic [lsfs_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic                         dbit_r, dbit_nxt;
  logic                         pulse_r, pulse_nxt;
  logic                         busy_res_r;
  logic                         done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r    <= in_cmd;
      idx_r    <= in_pixel_index;
      red_r    <= in_red;
      green_r  <= in_green;
      blue_r   <= in_blue;
      packed_r <= in_packed_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= lsfs_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (chan_r == lsfs_pkg::CH_BLUE) begin
      step_led  = led_r + 1'b1;
      step_chan = lsfs_pkg::CH_GREEN;
    end else begin
      step_led  = led_r;
      step_chan = chan_r + 1'b1;
    end
  end

  // The store is read when the request is taken, so its data is ready
  // during execution.
  always_comb begin
    priority if (in_cmd == lsfs_pkg::CMD_READ) begin
      ram_raddr = in_pixel_index[lsfs_pkg::ADDR_W-1:0];
    end else if (in_cmd == lsfs_pkg::CMD_START) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = step_led[lsfs_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      rd_valid_r <= pix_valid_r[ram_raddr];
    end
  end

  lsfs_ram #(
    .WIDTH (lsfs_pkg::PIX_W),
    .DEPTH (lsfs_pkg::MAX_LEDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r[lsfs_pkg::ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ctrl.capture),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= '0;
    end else if (ram_we) begin
      pix_valid_r[idx_r[lsfs_pkg::ADDR_W-1:0]] <= 1'b1;
    end
  end

  assign index_ok = (idx_r < lsfs_pkg::IDX_W'(active_r)) &&
                    ({1'b0, idx_r} < (lsfs_pkg::IDX_W + 1)'(lsfs_pkg::MAX_LEDS));

  always_comb begin
    unique case (step_chan)
      lsfs_pkg::CH_GREEN: step_ch = ram_rdata[3*lsfs_pkg::CH_W-1:2*lsfs_pkg::CH_W];
      lsfs_pkg::CH_RED:   step_ch = ram_rdata[2*lsfs_pkg::CH_W-1:lsfs_pkg::CH_W];
      default:            step_ch = ram_rdata[lsfs_pkg::CH_W-1:0];
    endcase
  end

  // A stored byte always has its top bit set; a never-written pixel is zero,
  // and so is the latch byte after the last pixel.
  assign step_byte  = ((step_led != LAST_LED) && rd_valid_r) ? {1'b1, step_ch} : 8'h00;
  assign first_byte = rd_valid_r ?
                      {1'b1, ram_rdata[3*lsfs_pkg::CH_W-1:2*lsfs_pkg::CH_W]} : 8'h00;

  always_comb begin
    sending_nxt = sending_r;
    priming_nxt = priming_r;
    led_nxt     = led_r;
    chan_nxt    = chan_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    color_nxt   = '0;
    dbit_nxt    = 1'b0;
    pulse_nxt   = 1'b0;
    done_nxt    = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = {green_r[6:0], red_r[6:0], blue_r[6:0]};
    if (ctrl.execute) begin
      unique case (cmd_r)
        lsfs_pkg::CMD_WRITE_CH: begin
          ram_we = index_ok;
        end
        lsfs_pkg::CMD_WRITE_PKD: begin
          ram_we    = index_ok;
          ram_wdata = {packed_r[22:16], packed_r[14:8], packed_r[6:0]};
        end
        lsfs_pkg::CMD_READ: begin
          if (index_ok && rd_valid_r) begin
            color_nxt = {ram_rdata[3*lsfs_pkg::CH_W-1:2*lsfs_pkg::CH_W], 1'b0,
                         ram_rdata[2*lsfs_pkg::CH_W-1:lsfs_pkg::CH_W], 1'b0,
                         ram_rdata[lsfs_pkg::CH_W-1:0]};
          end
        end
        lsfs_pkg::CMD_START: begin
          if (!sending_r && !priming_r) begin
            sending_nxt = 1'b1;
            led_nxt     = '0;
            chan_nxt    = lsfs_pkg::CH_GREEN;
            bit_nxt     = 3'd7;
            shift_nxt   = first_byte;
          end
        end
        lsfs_pkg::CMD_TICK: begin
          if (sending_r || priming_r) begin
            dbit_nxt  = shift_r[bit_r];
            pulse_nxt = 1'b1;
            bit_nxt   = bit_r - 1'b1;
            if (bit_r == 3'd0) begin
              bit_nxt = 3'd7;
              if (priming_r) begin
                priming_nxt = 1'b0;
                done_nxt    = 1'b1;
              end else if (led_r == LAST_LED) begin
                // The latch byte has gone out: the frame is complete.
                sending_nxt = 1'b0;
                done_nxt    = 1'b1;
                led_nxt     = '0;
                chan_nxt    = lsfs_pkg::CH_GREEN;
                shift_nxt   = 8'h00;
              end else begin
                led_nxt   = step_led;
                chan_nxt  = step_chan;
                shift_nxt = step_byte;
              end
            end
          end
        end
        lsfs_pkg::CMD_PRIME: begin
          if (!sending_r && !priming_r) begin
            priming_nxt = 1'b1;
            bit_nxt     = 3'd7;
            shift_nxt   = 8'h00;
          end
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      priming_r <= 1'b0;
      led_r     <= '0;
      chan_r    <= lsfs_pkg::CH_GREEN;
      bit_r     <= 3'd7;
      shift_r   <= 8'h00;
    end else begin
      sending_r <= sending_nxt;
      priming_r <= priming_nxt;
      led_r     <= led_nxt;
      chan_r    <= chan_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.execute;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      color_r    <= color_nxt;
      dbit_r     <= dbit_nxt;
      pulse_r    <= pulse_nxt;
      busy_res_r <= sending_nxt | priming_nxt;
      done_r     <= done_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_color    = color_r;
  assign out_data_bit      = dbit_r;
  assign out_clock_pulse   = pulse_r;
  assign out_busy_res      = busy_res_r;
  assign out_sequence_done = done_r;

  // A frame and a prime sequence never run at the same time.
  a_one_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    !(sending_r && priming_r))
    else $error("frame and prime sequence active together");

  // The frame position never passes the latch byte.
  a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
    (led_r < LAST_LED) || ((led_r == LAST_LED) && (chan_r == lsfs_pkg::CH_GREEN)))
    else $error("frame position beyond latch byte");

  // Outside a frame the position rests at the first byte.
  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> ((led_r == '0) && (chan_r == lsfs_pkg::CH_GREEN)))
    else $error("frame position not cleared outside a frame");

  // The end of a sequence is always marked on a clock pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (pulse_r && !busy_res_r))
    else $error("sequence end without a pulse or while still busy");

  // Execution is always followed by the idle state, so result strobes never touch.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobes in consecutive cycles");

endmodule

@@ design/led_strip_frame_shifter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame shifter
// Pixel store for a two-wire LED strip with a serial frame shifter.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// For every request, the pixel store is read in the cycle the
// request is taken and the request executes in the next, while busy is high.
// Its result is on the out_ ports for exactly one cycle, marked by out_valid,
// in the cycle after execution; the receiver cannot stall it and must take
// it then. A new request may be issued in that same cycle; the block takes
// no new request while one executes.
//
// Commands: write channels, write packed, read, start frame, tick and prime.
// Each pixel keeps three 7-bit channels in green, red, blue order; on the
// strip every stored byte goes out with its top bit set. Reads and writes at
// or beyond active_leds (or the store size) are dropped, and such a read
// returns zero. A start frame makes the following ticks shift out every
// pixel byte of the whole store and then one zero latch byte, most
// significant bit first. A prime makes eight ticks shift out zero bits.
// Start and prime are ignored while a sequence runs; a tick while idle gives
// no pulse and an all-zero result. A write during a frame reaches the strip
// if its byte has not yet been loaded into the shift register.
//
// The pixel store comes out of reset reading as all zero: each pixel has a
// written flag that reset clears at once, so there is no clearing pass.
// active_leds is written through cfg_we/cfg_wdata and may only change while
// no request is in flight.
// ----------------------------------------------------------------------------
module led_strip_frame_shifter (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_cmd,
  input  logic [lsfs_pkg::IDX_W-1:0]    in_pixel_index,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  input  logic [23:0]                   in_packed_color,
  // Result channel.
  output logic                          out_valid,
  output logic [lsfs_pkg::COLOR_W-1:0]  out_read_color,
  output logic                          out_data_bit,
  output logic                          out_clock_pulse,
  output logic                          out_busy_res,
  output logic                          out_sequence_done,
  // Configuration.
  input  logic                          cfg_we,
  input  logic [lsfs_pkg::ACT_W-1:0]    cfg_wdata
);

  lsfs_pkg::ctrl_t ctrl;

  // The controller sequences capture and execution of each request.
  lsfs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // The datapath holds the pixel store, the frame counters and the results.
  lsfs_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_pixel_index    (in_pixel_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_packed_color   (in_packed_color),
    .out_valid         (out_valid),
    .out_read_color    (out_read_color),
    .out_data_bit      (out_data_bit),
    .out_clock_pulse   (out_clock_pulse),
    .out_busy_res      (out_busy_res),
    .out_sequence_done (out_sequence_done)
  );

endmodule
